// ===== hw/rtl/pdbmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbmd_pkg
// shared types and constants of the balance-loop pd motor drive
// ----------------------------------------------------------------------------
package pdbmd_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration write channel
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN      = 3'd0,
        REG_KD_GAIN      = 3'd1,
        REG_FILTER_ALPHA = 3'd2,
        REG_OUTPUT_LIMIT = 3'd3,
        REG_DEAD_ZONE    = 3'd4
    } pdbmd_reg_idx_t;

    typedef enum logic [1:0] {
        DIR_STOP     = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } pdbmd_dir_t;

    localparam logic [3:0] PINS_FORWARD  = 4'b0110;
    localparam logic [3:0] PINS_BACKWARD = 4'b1001;
    localparam logic [3:0] PINS_STOP     = 4'b0000;

    localparam logic signed [15:0] HALF_Q88     = 16'sd128;
    localparam logic signed [17:0] ONE_Q016     = 18'sd65536;
    localparam logic [14:0]        LIMIT_RESET  = 15'd25600;

    typedef struct packed {
        logic signed [15:0] kp_gain;
        logic signed [15:0] kd_gain;
        logic [15:0]        filter_alpha;
        logic [14:0]        output_limit;
        logic [14:0]        dead_zone;
    } pdbmd_cfg_t;

endpackage

// ===== hw/rtl/pdbmd_sample_if.sv =====
// ----------------------------------------------------------------------------
// pdbmd_sample_if
// sensor sample channel: pitch, target and gyro rate
// ----------------------------------------------------------------------------
interface pdbmd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] target_angle;
    logic signed [15:0] gyro_rate;

    modport source (output valid, output pitch_angle, output target_angle,
                    output gyro_rate, input ready);
    modport sink   (input valid, input pitch_angle, input target_angle,
                    input gyro_rate, output ready);
endinterface

// ===== hw/rtl/pdbmd_result_if.sv =====
// ----------------------------------------------------------------------------
// pdbmd_result_if
// drive result channel: direction, bridge pins, output and duty
// ----------------------------------------------------------------------------
interface pdbmd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         drive_direction;
    logic [3:0]         bridge_pins;
    logic signed [15:0] pd_output;
    logic [15:0]        duty_value;

    modport source (output valid, output drive_direction, output bridge_pins,
                    output pd_output, output duty_value, input ready);
    modport sink   (input valid, input drive_direction, input bridge_pins,
                    input pd_output, input duty_value, output ready);
endinterface

// ===== hw/rtl/pdbmd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pdbmd_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface pdbmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pd_balance_motor_drive_top.sv =====
// ----------------------------------------------------------------------------
// pd_balance_motor_drive_top
// balance-loop pd controller with filtered derivative driving an h-bridge
// ----------------------------------------------------------------------------
// a sample steps through ST_P, ST_D, ST_LA, ST_LB, ST_LC, ST_SUM and ST_FIN (alpha zero
//   skips ST_LB and ST_LC); the next sample is taken only back in idle, as the one shared
//   multiplier forms kp*err, kd*gyro, alpha*lpf and (1-alpha)*d in turn
// a finished result waits in the output register; the next sample is taken
//   meanwhile and stalls only in its last step if the result is still pending
// reset: gains, alpha and dead zone clear, limit goes to 100.0, filter clears
// ----------------------------------------------------------------------------
module pd_balance_motor_drive_top (
    input  logic             clk,
    input  logic             rst_n,
    pdbmd_sample_if.sink     sample,
    pdbmd_result_if.source   result,
    pdbmd_cfg_if.sink        cfg
);
    import pdbmd_pkg::*;

    // sequencer steps; ST_P to ST_LB each issue one multiplier operation
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P,       // issue err*kp
        ST_D,       // issue gyro*kd, take p
        ST_LA,      // issue lpf*alpha, take d
        ST_LB,      // issue d*(1-alpha), take alpha*lpf
        ST_LC,      // accumulate and rescale filter
        ST_SUM,     // p + lpf and clamp
        ST_FIN      // direction, pins, duty into output register
    } state_t;

    pdbmd_cfg_t regs;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [MUL_P_W-1:0] product;

    state_t                    state_reg,   state_next;
    logic signed [15:0]        err_reg,     err_next;
    logic signed [15:0]        gyro_reg,    gyro_next;
    logic signed [23:0]        p_reg,       p_next;
    logic signed [23:0]        d_reg,       d_next;
    logic signed [MUL_P_W-1:0] acc_reg,     acc_next;
    logic signed [31:0]        lpf_reg,     lpf_next;
    logic signed [15:0]        sum_reg,     sum_next;
    logic                      ovalid_reg,  ovalid_next;
    pdbmd_dir_t                dir_reg,     dir_next;
    logic [3:0]                pins_reg,    pins_next;
    logic signed [15:0]        out_reg,     out_next;
    logic [15:0]               duty_reg,    duty_next;

    // working values
    logic signed [16:0]        diff;
    logic signed [MUL_P_W:0]   lpf_total;
    logic signed [35:0]        lpf_scaled;
    logic signed [32:0]        sum_wide;
    logic signed [32:0]        limit_pos;
    logic [15:0]               mag;
    logic [16:0]               duty_wide;
    logic                      out_free;

    pdbmd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pdbmd_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    assign sample.ready           = (state_reg == ST_IDLE);
    assign result.valid           = ovalid_reg;
    assign result.drive_direction = dir_reg;
    assign result.bridge_pins     = pins_reg;
    assign result.pd_output       = out_reg;
    assign result.duty_value      = duty_reg;

    // output register is free when empty or its result transfers now
    assign out_free = !ovalid_reg || result.ready;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_P:
            begin
                op_a = MUL_A_W'(err_reg);
                op_b = MUL_B_W'(regs.kp_gain);
            end
            ST_D:
            begin
                op_a = MUL_A_W'(gyro_reg);
                op_b = MUL_B_W'(regs.kd_gain);
            end
            ST_LA:
            begin
                op_a = MUL_A_W'(lpf_reg);
                op_b = $signed({2'b00, regs.filter_alpha});
            end
            ST_LB:
            begin
                op_a = MUL_A_W'(d_reg);
                op_b = ONE_Q016 - $signed({2'b00, regs.filter_alpha});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // arithmetic around the sequencer
    always_comb
    begin
        // pitch error, saturated to 16 bits when the sample is taken
        diff = 17'(sample.pitch_angle) - 17'(sample.target_angle);

        // filter: alpha*lpf + (1-alpha)*d, floor by 2^16, saturate to 32 bits
        lpf_total  = (MUL_P_W + 1)'(acc_reg) + (MUL_P_W + 1)'(product);
        lpf_scaled = lpf_total[MUL_P_W:16];

        // p + lpf clamped to the symmetric limit
        sum_wide  = 33'(p_reg) + 33'(lpf_reg);
        limit_pos = $signed({18'd0, regs.output_limit});

        // duty from magnitude plus dead zone
        mag       = sum_reg[15] ? 16'(-sum_reg) : 16'(sum_reg);
        duty_wide = {1'b0, mag} + {2'b00, regs.dead_zone};
    end

    always_comb
    begin
        state_next  = state_reg;
        err_next    = err_reg;
        gyro_next   = gyro_reg;
        p_next      = p_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        lpf_next    = lpf_reg;
        sum_next    = sum_reg;
        ovalid_next = ovalid_reg;
        dir_next    = dir_reg;
        pins_next   = pins_reg;
        out_next    = out_reg;
        duty_next   = duty_reg;

        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    if (diff[16] != diff[15])
                    begin
                        err_next = diff[16] ? 16'sh8000 : 16'sh7fff;
                    end
                    else
                    begin
                        err_next = diff[15:0];
                    end
                    gyro_next  = sample.gyro_rate;
                    state_next = ST_P;
                end
            end
            ST_P:
            begin
                state_next = ST_D;
            end
            ST_D:
            begin
                p_next     = product[31:8];
                state_next = ST_LA;
            end
            ST_LA:
            begin
                d_next = product[31:8];
                // alpha zero bypasses the filter
                if (regs.filter_alpha == '0)
                begin
                    lpf_next   = 32'($signed(product[31:8]));
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_LB;
                end
            end
            ST_LB:
            begin
                acc_next   = product;
                state_next = ST_LC;
            end
            ST_LC:
            begin
                if (lpf_scaled[35:31] != {5{lpf_scaled[35]}})
                begin
                    lpf_next = lpf_scaled[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end
                else
                begin
                    lpf_next = lpf_scaled[31:0];
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                priority if (sum_wide > limit_pos)
                begin
                    sum_next = limit_pos[15:0];
                end
                else if (sum_wide < -limit_pos)
                begin
                    sum_next = 16'(-limit_pos);
                end
                else
                begin
                    sum_next = sum_wide[15:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    priority if (sum_reg > HALF_Q88)
                    begin
                        dir_next  = DIR_FORWARD;
                        pins_next = PINS_FORWARD;
                    end
                    else if (sum_reg < -HALF_Q88)
                    begin
                        dir_next  = DIR_BACKWARD;
                        pins_next = PINS_BACKWARD;
                    end
                    else
                    begin
                        dir_next  = DIR_STOP;
                        pins_next = PINS_STOP;
                    end
                    out_next    = sum_reg;
                    duty_next   = duty_wide[16] ? 16'hffff : duty_wide[15:0];
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            err_reg    <= '0;
            gyro_reg   <= '0;
            p_reg      <= '0;
            d_reg      <= '0;
            acc_reg    <= '0;
            lpf_reg    <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
            dir_reg    <= DIR_STOP;
            pins_reg   <= PINS_STOP;
            out_reg    <= '0;
            duty_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            err_reg    <= err_next;
            gyro_reg   <= gyro_next;
            p_reg      <= p_next;
            d_reg      <= d_next;
            acc_reg    <= acc_next;
            lpf_reg    <= lpf_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
            dir_reg    <= dir_next;
            pins_reg   <= pins_next;
            out_reg    <= out_next;
            duty_reg   <= duty_next;
        end
    end

endmodule

// ===== hw/rtl/pdbmd_mul.sv =====
// ----------------------------------------------------------------------------
// pdbmd_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pdbmd_mul (
    input  logic                                 clk,
    input  logic signed [pdbmd_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [pdbmd_pkg::MUL_B_W-1:0] op_b,
    output logic signed [pdbmd_pkg::MUL_P_W-1:0] product
);
    import pdbmd_pkg::*;

    logic signed [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(op_a * op_b);
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/pdbmd_cfg.sv =====
// ----------------------------------------------------------------------------
// pdbmd_cfg
// configuration register file, unknown indexes are dropped
// ----------------------------------------------------------------------------
module pdbmd_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    pdbmd_cfg_if.sink             cfg,
    output pdbmd_pkg::pdbmd_cfg_t regs
);
    import pdbmd_pkg::*;

    pdbmd_cfg_t regs_reg;
    pdbmd_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (pdbmd_reg_idx_t'(cfg.index))
                REG_KP_GAIN:      regs_next.kp_gain      = cfg.data;
                REG_KD_GAIN:      regs_next.kd_gain      = cfg.data;
                REG_FILTER_ALPHA: regs_next.filter_alpha = cfg.data;
                REG_OUTPUT_LIMIT: regs_next.output_limit = cfg.data[14:0];
                REG_DEAD_ZONE:    regs_next.dead_zone    = cfg.data[14:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kp_gain      <= '0;
            regs_reg.kd_gain      <= '0;
            regs_reg.filter_alpha <= '0;
            regs_reg.output_limit <= LIMIT_RESET;
            regs_reg.dead_zone    <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
